// ===== rtl/rotenc_pkg.sv =====
// Package for the rotary encoder detent decoder: transfer types, turn codes,
// quadrature step table and default sizes. No dependencies.

package rotenc_pkg;

    localparam int COUNT_WIDTH_DEF      = 32;
    localparam int STEPS_PER_DETENT_DEF = 3;
    localparam int TIME_W               = 32;
    localparam int LOCKOUT_W            = 16;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd200;

    // Bit n set: transition code n ({last A, last B, A, B}) counts up / down.
    localparam logic [15:0] UP_CODES   = 16'h2814;  // 1101 0100 0010 1011
    localparam logic [15:0] DOWN_CODES = 16'h4182;  // 1110 0111 0001 1000

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_RIGHT = 2'd1,
        TURN_LEFT  = 2'd2
    } t_turn;

    typedef enum logic [1:0] {
        STEP_HOLD,
        STEP_UP,
        STEP_DOWN
    } t_step;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              pin_a;
        logic              pin_b;
    } t_in_item;

    typedef struct packed {
        logic [1:0] turn_event;
        logic       accepted;
    } t_out_item;

    // Command from the top level to the decoder for one item
    typedef struct packed {
        logic       en;
        logic [1:0] ab;
    } t_dec_cmd;

    function automatic t_step step_of(input logic [3:0] code);
        t_step s;
        if (UP_CODES[code]) begin
            s = STEP_UP;
        end else if (DOWN_CODES[code]) begin
            s = STEP_DOWN;
        end else begin
            s = STEP_HOLD;
        end
        return s;
    endfunction

endpackage

// ===== rtl/rotenc_lockout.sv =====
// Lockout window: holds the lockout register and the last accepted timestamp.
// Depends on rotenc_pkg.

module rotenc_lockout (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rotenc_pkg::LOCKOUT_W-1:0] i_cfg_data,
    input  logic [rotenc_pkg::TIME_W-1:0]    i_time_ms,
    input  logic                             i_fire,
    output logic                             o_pass
);
    import rotenc_pkg::*;

    logic [LOCKOUT_W-1:0] r_lockout;
    logic [TIME_W-1:0]    r_last_time;
    logic [TIME_W-1:0]    elapsed;

    // Elapsed time wraps modulo 2^32; must exceed the lockout strictly
    assign elapsed = i_time_ms - r_last_time;
    assign o_pass  = elapsed > {{(TIME_W-LOCKOUT_W){1'b0}}, r_lockout};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout   <= LOCKOUT_RESET;
            r_last_time <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lockout <= i_cfg_data;
            end
            if (i_fire && o_pass) begin
                r_last_time <= i_time_ms;
            end
        end
    end

endmodule

// ===== rtl/rotenc_decode.sv =====
// Quadrature decoder: last AB pair, wrapping position counter and the
// position's phase within a detent. Depends on rotenc_pkg.

module rotenc_decode #(
    parameter int COUNT_WIDTH      = rotenc_pkg::COUNT_WIDTH_DEF,
    parameter int STEPS_PER_DETENT = rotenc_pkg::STEPS_PER_DETENT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rotenc_pkg::t_dec_cmd i_cmd,
    output rotenc_pkg::t_turn    o_turn
);
    import rotenc_pkg::*;

    localparam int PH_W = (STEPS_PER_DETENT > 1) ? $clog2(STEPS_PER_DETENT) : 1;
    localparam logic [COUNT_WIDTH-1:0] MAX_POS  = '1;
    localparam logic [COUNT_WIDTH-1:0] WRAP_REM = MAX_POS % COUNT_WIDTH'(STEPS_PER_DETENT);
    localparam logic [PH_W-1:0] WRAP_PHASE = WRAP_REM[PH_W-1:0];
    localparam logic [PH_W-1:0] PHASE_TOP  = PH_W'(STEPS_PER_DETENT - 1);
    // Across a counter wrap the detent index moves by one only with one step per detent
    localparam bit WRAP_TURNS = (STEPS_PER_DETENT == 1);

    logic [1:0]             r_last_ab;
    logic [COUNT_WIDTH-1:0] r_pos;
    logic [PH_W-1:0]        r_phase;
    logic [COUNT_WIDTH-1:0] n_pos;
    logic [PH_W-1:0]        n_phase;
    t_step                  step;
    t_turn                  turn;

    assign step = step_of({r_last_ab, i_cmd.ab});

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        turn    = TURN_NONE;
        case (step)
            STEP_UP: begin
                n_pos = r_pos + 1'b1;
                if (r_pos == MAX_POS) begin
                    n_phase = '0;
                    turn    = WRAP_TURNS ? TURN_RIGHT : TURN_NONE;
                end else if (r_phase == PHASE_TOP) begin
                    n_phase = '0;
                    turn    = TURN_RIGHT;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            STEP_DOWN: begin
                n_pos = r_pos - 1'b1;
                if (r_pos == '0) begin
                    n_phase = WRAP_PHASE;
                    turn    = WRAP_TURNS ? TURN_LEFT : TURN_NONE;
                end else if (r_phase == '0) begin
                    n_phase = PHASE_TOP;
                    turn    = TURN_LEFT;
                end else begin
                    n_phase = r_phase - 1'b1;
                end
            end
            default: begin
                n_pos   = r_pos;
                n_phase = r_phase;
                turn    = TURN_NONE;
            end
        endcase
    end

    assign o_turn = i_cmd.en ? turn : TURN_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ab <= '0;
            r_pos     <= '0;
            r_phase   <= '0;
        end else if (i_cmd.en) begin
            r_last_ab <= i_cmd.ab;
            r_pos     <= n_pos;
            r_phase   <= n_phase;
        end
    end

endmodule

// ===== rtl/rotary_encoder_detent_decoder_top.sv =====
// Top level of the rotary encoder detent decoder: input register, lockout
// window, quadrature decoder and result register. Depends on rotenc_pkg,
// rotenc_lockout and rotenc_decode.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------------------
//  in        | to block  | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out       | from block| o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg       | to block  | i_cfg_valid / o_cfg_ready | i_cfg_data (lockout_ms)
//
// One item per cycle sustained while the output is not stalled; a result
// passes through the input register, then the result register, before it
// is offered and can transfer out.
// The decode stage updates all state in the cycle the item moves into the
// result register, so the next item may follow directly.
// Synchronous active-low reset clears both stages, the decoder state and
// sets the lockout to 200 ms.
// A stall on the output holds the result register; the input stalls only
// when both stages are full and the output is stalled.

module rotary_encoder_detent_decoder_top #(
    parameter int COUNT_WIDTH      = rotenc_pkg::COUNT_WIDTH_DEF,
    parameter int STEPS_PER_DETENT = rotenc_pkg::STEPS_PER_DETENT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  rotenc_pkg::t_in_item             i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output rotenc_pkg::t_out_item            o_out_data,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_valid,
    input  logic [rotenc_pkg::LOCKOUT_W-1:0] i_cfg_data,
    output logic                             o_cfg_ready
);
    import rotenc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      fire;
    logic      pass;
    t_dec_cmd  cmd;
    t_turn     turn;

    // Advance the decode stage when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign o_cfg_ready = 1'b1;

    rotenc_lockout u_lockout (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_time_ms  (r_in.time_ms),
        .i_fire     (fire),
        .o_pass     (pass)
    );

    // Drop the item into the decoder only if it clears the lockout
    assign cmd.en = fire && pass;
    assign cmd.ab = {r_in.pin_a, r_in.pin_b};

    rotenc_decode #(
        .COUNT_WIDTH      (COUNT_WIDTH),
        .STEPS_PER_DETENT (STEPS_PER_DETENT)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_turn  (turn)
    );

    assign n_out.turn_event = turn;
    assign n_out.accepted   = pass;

    // Input register: take a new transfer whenever it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result register: hold while stalled, load on fire, empty after transfer out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/rotenc_checker.sv =====
// Port-level checker for the rotary encoder detent decoder, bound to the
// top level. Depends on rotenc_pkg and rotary_encoder_detent_decoder_top.

module rotenc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input rotenc_pkg::t_out_item o_out_data,
    input logic                  i_out_stall
);
    import rotenc_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A turn is reported only for an accepted edge
    a_turn_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.turn_event != TURN_NONE) |-> o_out_data.accepted)
        else $error("turn reported for an ignored edge");

    // The input backs up only behind a stalled, full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    // An item transferred in reaches the output when the output does not stall
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("result missing two cycles after transfer in");

endmodule

bind rotary_encoder_detent_decoder_top rotenc_checker u_rotenc_checker (.*);

// ===== tb/rotary_encoder_detent_decoder_top_tb.sv =====
// Self-checking testbench for rotary_encoder_detent_decoder_top: drives pin-edge
// events and lockout writes, predicts each result in-house and checks every transfer.
// Depends on rotenc_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module rotary_encoder_detent_decoder_top_tb;
    import rotenc_pkg::*;

    localparam real CLK_PERIOD = 12.0;
    localparam int  CW         = COUNT_WIDTH_DEF;
    localparam int  LONG_HOLD  = 150;      // long receiver hold-off, in cycles
    localparam int  PHASE_DEC  = 125;      // decoded events per lockout setting
    localparam int  N_PHASES   = 5;
    localparam int  N_PLAN     = 17;

    localparam logic [CW-1:0] DETENT_STEPS = STEPS_PER_DETENT_DEF;

    // One directed row: pin levels as {A,B}; pinned rows carry a typed result.
    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [1:0]        ab;
        logic              pinned;
        t_turn             turn;
        logic              acc;
    } t_plan_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [LOCKOUT_W-1:0] i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 o_cfg_ready;

    // Predictor state, mirrors the block
    logic [LOCKOUT_W-1:0] lock_ms;
    logic [TIME_W-1:0]    last_edge_time;
    logic [1:0]           last_pins;
    logic [CW-1:0]        quad_pos;
    logic [CW-1:0]        detent_pos;

    t_out_item expected_turns[$];

    int  err_cnt     = 0;
    int  n_edges     = 0;
    int  n_decoded   = 0;
    int  n_right     = 0;
    int  n_left      = 0;
    int  n_lock_sets = 0;
    int  hold_asks   = 0;   // bumped by the sender side to request one long hold
    int  hold_seen   = 0;
    int  hold_cnt    = 0;
    int  n_results   = 0;
    bit  tx_calm     = 1'b0;
    bit  rx_calm     = 1'b0;

    // Directed table. Rows with a typed result: power-up lockout window
    // (ignored at 0 and at exactly 200 ms), first decode stepping the counter
    // down through zero (wrap, no turn), the step back up, a too-early edge,
    // and an edge that is too early only because the timestamp wrapped.
    t_plan_row plan [0:N_PLAN-1] = '{
        '{32'd0,          2'b11, 1'b1, TURN_NONE, 1'b0},
        '{32'd200,        2'b11, 1'b1, TURN_NONE, 1'b0},
        '{32'd201,        2'b01, 1'b1, TURN_NONE, 1'b1},
        '{32'd402,        2'b00, 1'b1, TURN_NONE, 1'b1},
        '{32'd603,        2'b10, 1'b0, TURN_NONE, 1'b0},
        '{32'd804,        2'b11, 1'b0, TURN_NONE, 1'b0},
        '{32'd1005,       2'b01, 1'b0, TURN_NONE, 1'b0},
        '{32'd1100,       2'b00, 1'b1, TURN_NONE, 1'b0},
        '{32'd1206,       2'b00, 1'b0, TURN_NONE, 1'b0},
        '{32'd1407,       2'b11, 1'b0, TURN_NONE, 1'b0},
        '{32'd1608,       2'b11, 1'b0, TURN_NONE, 1'b0},
        '{32'd1809,       2'b10, 1'b0, TURN_NONE, 1'b0},
        '{32'd2010,       2'b00, 1'b0, TURN_NONE, 1'b0},
        '{32'hFFFF_FF00,  2'b01, 1'b0, TURN_NONE, 1'b0},
        '{32'hFFFF_FFFF,  2'b00, 1'b0, TURN_NONE, 1'b0},
        '{32'h0000_0010,  2'b10, 1'b1, TURN_NONE, 1'b0},
        '{32'h0000_00C9,  2'b10, 1'b0, TURN_NONE, 1'b0}
    };

    rotary_encoder_detent_decoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // Decode one edge event against the predictor state and advance it.
    function automatic t_out_item decode_edge(input t_in_item ev);
        logic [TIME_W-1:0] elapsed;
        logic [3:0]        code;
        logic [CW-1:0]     idx;
        logic [CW-1:0]     fwd;
        logic [CW-1:0]     back;
        t_step             dir;
        t_out_item         res;
        res.turn_event = TURN_NONE;
        res.accepted   = 1'b0;
        elapsed = ev.time_ms - last_edge_time;
        // Strictly greater: an edge exactly lockout_ms after the last one is dropped
        if (elapsed > TIME_W'(lock_ms)) begin
            code = {last_pins, ev.pin_a, ev.pin_b};
            case (code)
                4'b1101, 4'b0100, 4'b0010, 4'b1011: dir = STEP_UP;
                4'b1110, 4'b0111, 4'b0001, 4'b1000: dir = STEP_DOWN;
                default:                            dir = STEP_HOLD;
            endcase
            if (dir == STEP_UP) begin
                quad_pos = quad_pos + 1'b1;
            end else if (dir == STEP_DOWN) begin
                quad_pos = quad_pos - 1'b1;
            end
            idx  = quad_pos / DETENT_STEPS;
            fwd  = idx - detent_pos;
            back = detent_pos - idx;
            // Only a one-detent move reports a turn; the jump across the wrap does not
            if (fwd == CW'(1)) begin
                res.turn_event = TURN_RIGHT;
            end else if (back == CW'(1)) begin
                res.turn_event = TURN_LEFT;
            end
            detent_pos     = idx;
            last_pins      = {ev.pin_a, ev.pin_b};
            last_edge_time = ev.time_ms;
            res.accepted   = 1'b1;
        end
        return res;
    endfunction

    // Next {A,B} one quadrature step clockwise (up) or counter-clockwise.
    function automatic logic [1:0] quad_next(input logic [1:0] ab, input logic cw_dir);
        logic [1:0] nxt;
        case (ab)
            2'b00:   nxt = cw_dir ? 2'b10 : 2'b01;
            2'b10:   nxt = cw_dir ? 2'b11 : 2'b00;
            2'b11:   nxt = cw_dir ? 2'b01 : 2'b10;
            default: nxt = cw_dir ? 2'b00 : 2'b11;
        endcase
        return nxt;
    endfunction

    // Offer one edge event after a random gap; hold it until the transfer.
    // Valid is left high after the transfer so a back-to-back item never
    // lowers and raises it in the same step; idle points drop it explicitly.
    task automatic send_edge(input logic [TIME_W-1:0] t, input logic [1:0] ab,
                             input logic pinned, input t_out_item fixed_res);
        t_in_item  ev;
        t_out_item res;
        int        gap;
        ev.time_ms = t;
        ev.pin_a   = ab[1];
        ev.pin_b   = ab[0];
        if (n_edges % 32 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
        end
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        res = decode_edge(ev);
        expected_turns.push_back(pinned ? fixed_res : res);
        n_edges++;
        if (res.accepted) n_decoded++;
        if (res.turn_event == TURN_RIGHT) n_right++;
        if (res.turn_event == TURN_LEFT) n_left++;
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic settle_block;
        i_in_valid <= 1'b0;
        while (expected_turns.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_lockout(input logic [LOCKOUT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lock_ms = value;
        n_lock_sets++;
    endtask

    // Result side: random stall before each transfer, calm stretches with no
    // stall at all, and one long hold-off when the sender asks for it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cnt    <= 0;
        end else if (hold_seen != hold_asks) begin
            hold_seen   <= hold_asks;
            hold_cnt    <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            int w;
            n_results <= n_results + 1;
            if (n_results % 32 == 0) begin
                rx_calm <= ($urandom_range(0, 3) == 0);
            end
            w = rx_calm ? 0 : $urandom_range(0, 15);
            i_out_stall <= (w != 0);
            hold_cnt    <= (w != 0) ? w - 1 : 0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_out_item want;
            if (expected_turns.size() == 0) begin
                $display("%0t: unexpected result turn=%0d accepted=%0d",
                         $time, o_out_data.turn_event, o_out_data.accepted);
                err_cnt++;
            end else begin
                want = expected_turns.pop_front();
                if (o_out_data.turn_event !== want.turn_event) begin
                    $display("%0t: turn_event mismatch: expected %0d, actual %0d",
                             $time, want.turn_event, o_out_data.turn_event);
                    err_cnt++;
                end
                if (o_out_data.accepted !== want.accepted) begin
                    $display("%0t: accepted mismatch: expected %0d, actual %0d",
                             $time, want.accepted, o_out_data.accepted);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : main_seq
        logic [LOCKOUT_W-1:0] lock_plan [0:N_PHASES-1];
        logic [TIME_W-1:0]    t;
        logic [1:0]           cur_ab;
        logic                 spin_cw;
        t_out_item            fixed_res;
        t_out_item            no_res;
        int                   base;
        bit                   held;
        bit                   paused;

        // Reset state of the predictor
        lock_ms        = LOCKOUT_RESET;
        last_edge_time = '0;
        last_pins      = 2'b00;
        quad_pos       = '0;
        detent_pos     = '0;
        no_res         = '0;
        cur_ab         = 2'b00;
        spin_cw        = 1'b1;
        held           = 1'b0;
        paused         = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run under the power-up lockout
        for (int r = 0; r < N_PLAN; r++) begin
            fixed_res.turn_event = plan[r].turn;
            fixed_res.accepted   = plan[r].acc;
            send_edge(plan[r].t, plan[r].ab, plan[r].pinned, fixed_res);
        end
        cur_ab = plan[N_PLAN-1].ab;

        // Random part: one lockout setting per phase, extremes first
        lock_plan[0] = 16'd0;
        lock_plan[1] = 16'hFFFF;
        lock_plan[2] = 16'd1;
        lock_plan[3] = LOCKOUT_W'($urandom_range(0, 65535));
        lock_plan[4] = LOCKOUT_RESET;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle_block();
            write_lockout(lock_plan[ph]);
            base = n_decoded;
            while (n_decoded - base < PHASE_DEC) begin
                // Hold the result side off long enough to fill both stages
                if (ph == 1 && !held && n_decoded - base == 60) begin
                    held = 1'b1;
                    hold_asks <= hold_asks + 1;
                end
                // Pause the sender until the pipeline has drained
                if (ph == 3 && !paused && n_decoded - base == 80) begin
                    paused = 1'b1;
                    settle_block();
                end
                // Timestamp relative to the last decoded edge: on and just past
                // the lockout boundary, inside the window, far jumps and wraps
                case ($urandom_range(0, 7))
                    0:       t = last_edge_time + lock_ms;
                    1:       t = last_edge_time + lock_ms + 1'b1;
                    2:       t = last_edge_time + $urandom_range(0, lock_ms);
                    3:       t = $urandom;
                    default: t = last_edge_time + lock_ms + 1'b1 + $urandom_range(0, 300);
                endcase
                // Mostly clean rotation with sticky direction, some pin noise
                if ($urandom_range(0, 11) == 0) begin
                    spin_cw = ~spin_cw;
                end
                if ($urandom_range(0, 9) == 0) begin
                    cur_ab = 2'($urandom_range(0, 3));
                end else begin
                    cur_ab = quad_next(cur_ab, spin_cw);
                end
                send_edge(t, cur_ab, 1'b0, no_res);
            end
        end

        settle_block();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d edge events: %0d decoded, %0d locked out, %0d right, %0d left",
                 n_edges, n_decoded, n_edges - n_decoded, n_right, n_left);
        $display("Lockout was rewritten %0d times, 0 and 65535 among the settings",
                 n_lock_sets);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(CLK_PERIOD * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rotenc_pkg.sv
rtl/rotenc_lockout.sv
rtl/rotenc_decode.sv
rtl/rotary_encoder_detent_decoder_top.sv
rtl/rotenc_checker.sv
tb/rotary_encoder_detent_decoder_top_tb.sv
